// ----- rtl/ksa_pkg.sv -----
package ksa_pkg;

    localparam int KEY_W  = 40;
    localparam int SLOT_W = 3;
    localparam int FREE_W = 4;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FN_ASSIGN = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_STATUS = 2'd3;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [FREE_W-1:0] t_free;

endpackage

// ----- rtl/ksa_if.sv -----
interface ksa_req_if;
    import ksa_pkg::*;
    logic  valid;
    logic  ready;
    t_func func;
    t_key  key;
    t_slot slot;

    modport source (output valid, output func, output key, output slot, input ready);
    modport sink   (input valid, input func, input key, input slot, output ready);
endinterface

interface ksa_rsp_if;
    import ksa_pkg::*;
    logic  valid;
    logic  ready;
    logic  ok;
    t_slot index;
    logic  occupied;
    t_free free_count;

    modport source (output valid, output ok, output index, output occupied,
                    output free_count, input ready);
    modport sink   (input valid, input ok, input index, input occupied,
                    input free_count, output ready);
endinterface

// ----- rtl/ksa_ram.sv -----
module ksa_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ksa_match.sv -----
module ksa_match #(
    parameter int KW = 40
) (
    input  logic          i_want_free,
    input  logic [KW-1:0] i_key,
    input  logic [KW-1:0] i_data,
    input  logic          i_mark,
    output logic          o_hit
);

    // free-slot search looks at the mark only; key search needs an occupied slot
    always_comb begin
        if (i_want_free) begin
            o_hit = !i_mark;
        end else begin
            o_hit = i_mark && (i_data == i_key);
        end
    end

endmodule

// ----- rtl/key_slot_allocator_cam_unit.sv -----
// Slot table of keys with first-free allocation and key lookup.
// Request channel i_req carries func, key and slot; response channel o_rsp
// carries ok, index, occupied and free_count. One response per request.
// Assign and find walk the table one slot per cycle through a single
// compare unit fed by the registered read port of the key RAM,
// stopping at the first hit. Remove and status, and assign into a
// full table, skip the scan and go straight to the response. One
// request is in flight at a time: i_req.ready is high only while the
// block is idle, and the next request is accepted the cycle after the
// response beat is taken. Occupied marks and the free count live in
// flops; reset clears them at once, so every slot is free and the
// block is ready in the first cycle after reset. Key RAM contents of a
// free slot are never looked at and need no clearing. A stalled
// receiver holds the response in its output registers; the block then
// takes no new request until that beat leaves.
module key_slot_allocator_cam_unit
    import ksa_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int KEY_BYTES = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ksa_req_if.sink   i_req,
    ksa_rsp_if.source o_rsp
);

    localparam int KW = (KEY_BYTES * 8 > KEY_W) ? KEY_W : KEY_BYTES * 8;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SLOTS-1:0] r_marks, n_marks;
    logic [CW-1:0]    r_free, n_free;
    logic [AW:0]      r_addr, n_addr;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_vld, n_rd_vld;
    logic             r_want_free, n_want_free;
    logic [KW-1:0]    r_key, n_key;
    logic             r_ok, n_ok;
    logic [SLOT_W-1:0] r_index, n_index;
    logic             r_occ, n_occ;

    logic              ram_we;
    logic [KW-1:0]     ram_rdata;
    logic              hit;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [AW-1:0]     slot_ix;
    logic              slot_ok;
    logic [AW+SLOT_W-1:0] idx_ext;
    logic [CW+FREE_W-1:0] free_ext;

    assign slot_ext = {{AW{1'b0}}, i_req.slot};
    assign slot_ix  = slot_ext[AW-1:0];
    assign slot_ok  = slot_ext < (AW + SLOT_W)'(SLOTS);
    assign idx_ext  = {{SLOT_W{1'b0}}, r_rd_idx};
    assign free_ext = {{FREE_W{1'b0}}, r_free};

    ksa_ram #(
        .WIDTH (KW),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_idx),
        .i_wdata (r_key),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    ksa_match #(
        .KW (KW)
    ) u_match (
        .i_want_free (r_want_free),
        .i_key       (r_key),
        .i_data      (ram_rdata),
        .i_mark      (r_marks[r_rd_idx]),
        .o_hit       (hit)
    );

    assign ram_we = (r_state == S_SCAN) && r_rd_vld && hit && r_want_free;

    always_comb begin
        n_state     = r_state;
        n_marks     = r_marks;
        n_free      = r_free;
        n_addr      = r_addr;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = r_rd_vld;
        n_want_free = r_want_free;
        n_key       = r_key;
        n_ok        = r_ok;
        n_index     = r_index;
        n_occ       = r_occ;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key       = i_req.key[KW-1:0];
                    n_want_free = (i_req.func == FN_ASSIGN);
                    n_addr      = '0;
                    n_rd_vld    = 1'b0;
                    n_ok        = 1'b0;
                    n_index     = '0;
                    n_occ       = 1'b0;
                    case (i_req.func)
                        FN_ASSIGN: begin
                            n_state = (r_free == '0) ? S_OUT : S_SCAN;
                        end
                        FN_FIND: begin
                            n_state = S_SCAN;
                        end
                        FN_REMOVE: begin
                            n_index = i_req.slot;
                            n_state = S_OUT;
                            if (slot_ok) begin
                                n_ok = 1'b1;
                                n_marks[slot_ix] = 1'b0;
                                if (r_marks[slot_ix]) begin
                                    n_free = r_free + CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_index = i_req.slot;
                            n_state = S_OUT;
                            if (slot_ok) begin
                                n_ok  = 1'b1;
                                n_occ = r_marks[slot_ix];
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue the next read while the previous one is compared
                if (r_addr < (AW + 1)'(SLOTS)) begin
                    n_rd_idx = r_addr[AW-1:0];
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + (AW + 1)'(1);
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld && hit) begin
                    n_ok    = 1'b1;
                    n_occ   = 1'b1;
                    n_index = idx_ext[SLOT_W-1:0];
                    n_state = S_OUT;
                    if (r_want_free) begin
                        n_marks[r_rd_idx] = 1'b1;
                        n_free = r_free - CW'(1);
                    end
                end else if (r_rd_vld && (r_rd_idx == AW'(SLOTS - 1))) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_marks  <= '0;
            r_free   <= CW'(SLOTS);
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_marks  <= n_marks;
            r_free   <= n_free;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_want_free <= n_want_free;
        r_key       <= n_key;
        r_ok        <= n_ok;
        r_index     <= n_index;
        r_occ       <= n_occ;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_OUT);
    assign o_rsp.ok         = r_ok;
    assign o_rsp.index      = r_index;
    assign o_rsp.occupied   = r_occ;
    assign o_rsp.free_count = free_ext[FREE_W-1:0];

`ifndef SYNTH
    a_free_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) == SLOTS - $countones(r_marks))
        else $error("free count out of step with occupied marks");

    a_occ_implies_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.occupied && (r_state == S_OUT) |-> o_rsp.ok)
        else $error("occupied reported without success");

    a_full_assign_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (i_req.func == FN_ASSIGN) && (r_free == '0)
        |=> o_rsp.valid && !o_rsp.ok)
        else $error("assign into full table did not fail at once");

    a_marks_stable_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && !ram_we |=> $stable(r_marks))
        else $error("marks changed during scan without an allocation");
`endif

endmodule
